[src/assert_macros.svh]
// Assertion macros shared by the matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define MPM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define MPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mpm_pkg.sv]
// Types, constants and codes of the multi-pattern matcher.
package mpm_pkg;

   localparam int TRIE_NODES      = 256;
   localparam int MAX_PATTERNS    = 255;
   localparam int MAX_PATTERN_LEN = 64;
   localparam int ALPHABET        = 256;
   localparam int GOTO_DEPTH      = TRIE_NODES * ALPHABET;
   localparam int GOTO_AW         = $clog2(GOTO_DEPTH);

   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_BUILD   = 2'd1;
   localparam logic [1:0] KIND_TEXT    = 2'd2;

   localparam logic STATUS_MATCH = 1'b0;
   localparam logic STATUS_DROP  = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  match_id;
      logic [31:0] match_total;
      logic [31:0] start_offset;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_PAT_RD, ST_PAT_UPD, ST_PAT_EMIT,
      ST_ROOT_RD, ST_ROOT_CHK, ST_POP, ST_BLD_U, ST_BLD_F, ST_BLD_RD, ST_BLD_WR,
      ST_TXT_RD, ST_TXT_STEP, ST_NODE, ST_ID, ST_HIT, ST_TXT_END
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic latch_item;
      logic pat_rd;
      logic pat_upd;
      logic load_ovf;
      logic bld_init;
      logic root_rd;
      logic root_chk;
      logic q_rd;
      logic bld_u;
      logic bld_f;
      logic bld_rd;
      logic bld_wr;
      logic set_built;
      logic txt_rd;
      logic txt_step;
      logic node_rd;
      logic id_chk;
      logic hit_go;
      logic txt_end;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic built;
      logic out_room;
      logic pat_ovf;
      logic sym_last;
      logic q_empty;
      logic j_zero;
      logic id_zero;
      logic pend_valid;
   } sts_type;

endpackage

[src/mpm_ctrl.sv]
// Sequencer for insert, build and scan operations of the matcher.
`include "assert_macros.svh"
module mpm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  mpm_pkg::req_type req_data,
   output logic             req_ready,
   input  mpm_pkg::sts_type sts,
   output mpm_pkg::cmd_type cmd
);
   import mpm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clear_en = 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               if (req_data.kind == KIND_PATTERN && !sts.built) begin
                  state_in = ST_PAT_RD;
               end else if (req_data.kind == KIND_BUILD && !sts.built) begin
                  cmd.bld_init = 1'b1;
                  state_in     = ST_ROOT_RD;
               end else if (req_data.kind == KIND_TEXT) begin
                  state_in = ST_TXT_RD;
               end
            end
         end
         ST_PAT_RD: begin
            cmd.pat_rd = 1'b1;
            state_in   = ST_PAT_UPD;
         end
         ST_PAT_UPD: begin
            cmd.pat_upd = 1'b1;
            state_in    = sts.pat_ovf ? ST_PAT_EMIT : ST_IDLE;
         end
         ST_PAT_EMIT: begin
            if (sts.out_room) begin
               cmd.load_ovf = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ROOT_RD: begin
            cmd.root_rd = 1'b1;
            state_in    = ST_ROOT_CHK;
         end
         ST_ROOT_CHK: begin
            cmd.root_chk = 1'b1;
            state_in     = sts.sym_last ? ST_POP : ST_ROOT_RD;
         end
         ST_POP: begin
            if (sts.q_empty) begin
               cmd.set_built = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.q_rd = 1'b1;
               state_in = ST_BLD_U;
            end
         end
         ST_BLD_U: begin
            cmd.bld_u = 1'b1;
            state_in  = ST_BLD_F;
         end
         ST_BLD_F: begin
            cmd.bld_f = 1'b1;
            state_in  = ST_BLD_RD;
         end
         ST_BLD_RD: begin
            cmd.bld_rd = 1'b1;
            state_in   = ST_BLD_WR;
         end
         ST_BLD_WR: begin
            cmd.bld_wr = 1'b1;
            state_in   = sts.sym_last ? ST_POP : ST_BLD_RD;
         end
         ST_TXT_RD: begin
            cmd.txt_rd = 1'b1;
            state_in   = ST_TXT_STEP;
         end
         ST_TXT_STEP: begin
            cmd.txt_step = 1'b1;
            state_in     = ST_NODE;
         end
         ST_NODE: begin
            if (sts.j_zero) begin
               state_in = ST_TXT_END;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = ST_ID;
            end
         end
         ST_ID: begin
            cmd.id_chk = 1'b1;
            state_in   = sts.id_zero ? ST_NODE : ST_HIT;
         end
         ST_HIT: begin
            if (!sts.pend_valid || sts.out_room) begin
               cmd.hit_go = 1'b1;
               state_in   = ST_NODE;
            end
         end
         ST_TXT_END: begin
            if (!sts.pend_valid || sts.out_room) begin
               cmd.txt_end = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `MPM_ASSERT_NEXT(a_no_reclear, state_ff != ST_CLEAR, state_ff != ST_CLEAR, "clear pass re-entered")
   `MPM_ASSERT_SAME(a_take_idle, req_ready && cmd.bld_init, !sts.built, "build started twice")
   `MPM_ASSERT_SAME(a_ready_idle, req_ready, state_ff == ST_IDLE, "ready outside idle")

endmodule

[src/mpm_dp.sv]
// Trie memories, automaton registers and result staging of the matcher.
`include "assert_macros.svh"
module mpm_dp (
   input  logic             clock,
   input  logic             reset,
   input  mpm_pkg::req_type req_data,
   input  mpm_pkg::cmd_type cmd,
   output mpm_pkg::sts_type sts,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output mpm_pkg::rsp_type rsp_data
);
   import mpm_pkg::*;

   logic [7:0]  goto_mem  [GOTO_DEPTH];
   logic [7:0]  fail_mem  [TRIE_NODES];
   logic [7:0]  npat_mem  [TRIE_NODES];
   logic [6:0]  plen_mem  [MAX_PATTERNS + 1];
   logic [31:0] hit_mem   [MAX_PATTERNS + 1];
   logic [7:0]  queue_mem [TRIE_NODES];

   req_type     item_ff;
   logic [7:0]  ins_node_ff, nodes_used_ff, pat_used_ff, scan_ff;
   logic [6:0]  ins_len_ff;
   logic        ins_drop_ff, built_ff, clr_done_ff;
   logic [31:0] pos_ff;
   logic [7:0]  head_ff, sym_i_ff, u_ff, f_ff, j_ff, id_ff;
   logic [8:0]  tail_ff;
   logic [15:0] clr_cnt_ff;
   rsp_type     pend_ff, rsp_ff;
   logic        pend_v_ff, rsp_v_ff;

   logic [7:0]  ga_q, gb_q, fail_q, npat_q, queue_q;
   logic [6:0]  plen_q;
   logic [31:0] hit_q;

   // pattern insert step
   logic       p_drop, p_new, p_ovf;
   logic [7:0] p_child, p_node, p_nodes, p_pid;
   logic [6:0] p_len;

   always_comb begin
      p_drop  = ins_drop_ff;
      p_new   = 1'b0;
      p_child = ga_q;
      p_node  = ins_node_ff;
      p_len   = ins_len_ff;
      p_nodes = nodes_used_ff;
      if (!ins_drop_ff) begin
         if (ins_len_ff >= 7'(MAX_PATTERN_LEN)) begin
            p_drop = 1'b1;
         end else begin
            if (ga_q == 8'd0) begin
               if ({1'b0, nodes_used_ff} + 9'd1 >= 9'(TRIE_NODES)) begin
                  p_drop = 1'b1;
               end else begin
                  p_nodes = nodes_used_ff + 8'd1;
                  p_child = p_nodes;
                  p_new   = 1'b1;
               end
            end
            if (!p_drop) begin
               p_node = p_child;
               p_len  = ins_len_ff + 7'd1;
            end
         end
      end
      if (item_ff.final_byte && !p_drop && pat_used_ff >= 8'(MAX_PATTERNS)) begin
         p_drop = 1'b1;
      end
      p_ovf = item_ff.final_byte && p_drop;
      p_pid = pat_used_ff + 8'd1;
   end

   // goto memory ports
   logic                 g_we;
   logic [GOTO_AW-1:0]   g_wa, g_ra;
   logic [7:0]           g_wd;

   always_comb begin
      g_we = 1'b0;
      g_wa = {ins_node_ff, item_ff.symbol};
      g_wd = 8'd0;
      if (cmd.clear_en) begin
         g_we = 1'b1;
         g_wa = clr_cnt_ff;
      end else if (cmd.pat_upd && p_new) begin
         g_we = 1'b1;
         g_wd = p_child;
      end else if (cmd.bld_wr && ga_q == 8'd0) begin
         g_we = 1'b1;
         g_wa = {u_ff, sym_i_ff};
         g_wd = gb_q;
      end
      if (cmd.root_rd) begin
         g_ra = {8'd0, sym_i_ff};
      end else if (cmd.bld_rd) begin
         g_ra = {u_ff, sym_i_ff};
      end else if (cmd.txt_rd) begin
         g_ra = {scan_ff, item_ff.symbol};
      end else begin
         g_ra = {ins_node_ff, item_ff.symbol};
      end
   end

   always_ff @(posedge clock) begin
      if (g_we) begin
         goto_mem[g_wa] <= g_wd;
      end
      if (cmd.pat_rd || cmd.root_rd || cmd.bld_rd || cmd.txt_rd) begin
         ga_q <= goto_mem[g_ra];
      end
      if (cmd.bld_rd) begin
         gb_q <= goto_mem[{f_ff, sym_i_ff}];
      end
   end

   // per-node and per-id stores
   logic       clr_low;
   logic [7:0] fail_ra;
   assign clr_low = cmd.clear_en && clr_cnt_ff[15:8] == 8'd0;
   assign fail_ra = cmd.bld_u ? queue_q : j_ff;

   always_ff @(posedge clock) begin
      if (clr_low) begin
         fail_mem[clr_cnt_ff[7:0]] <= 8'd0;
      end else if (cmd.bld_wr && ga_q != 8'd0) begin
         fail_mem[ga_q] <= gb_q;
      end
      if (cmd.bld_u || cmd.node_rd) begin
         fail_q <= fail_mem[fail_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_low) begin
         npat_mem[clr_cnt_ff[7:0]] <= 8'd0;
      end else if (cmd.pat_upd && item_ff.final_byte && !p_drop) begin
         npat_mem[p_node] <= p_pid;
      end
      if (cmd.node_rd) begin
         npat_q <= npat_mem[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pat_upd && item_ff.final_byte && !p_drop) begin
         plen_mem[p_pid] <= p_len;
      end
      if (cmd.id_chk) begin
         plen_q <= plen_mem[npat_q];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_low) begin
         hit_mem[clr_cnt_ff[7:0]] <= 32'd0;
      end else if (cmd.hit_go) begin
         hit_mem[id_ff] <= hit_q + 32'd1;
      end
      if (cmd.id_chk) begin
         hit_q <= hit_mem[npat_q];
      end
   end

   logic push_en;
   logic [7:0] push_val;
   assign push_en  = (cmd.root_chk || cmd.bld_wr) && ga_q != 8'd0;
   assign push_val = ga_q;

   always_ff @(posedge clock) begin
      if (push_en) begin
         queue_mem[tail_ff[7:0]] <= push_val;
      end
      if (cmd.q_rd) begin
         queue_q <= queue_mem[head_ff];
      end
   end

   // match result built from the registered hit count and pattern length
   rsp_type hit_rsp;
   always_comb begin
      hit_rsp.status       = STATUS_MATCH;
      hit_rsp.match_id     = id_ff;
      hit_rsp.match_total  = hit_q + 32'd1;
      hit_rsp.start_offset = pos_ff - {25'd0, plen_q} + 32'd1;
      hit_rsp.last_of_run  = 1'b0;
   end

   // held match marked as the final one of its text byte
   rsp_type pend_last;
   always_comb begin
      pend_last             = pend_ff;
      pend_last.last_of_run = 1'b1;
   end

   logic out_room;
   assign out_room = !rsp_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_node_ff   <= 8'd0;
         ins_len_ff    <= 7'd0;
         ins_drop_ff   <= 1'b0;
         nodes_used_ff <= 8'd0;
         pat_used_ff   <= 8'd0;
         scan_ff       <= 8'd0;
         pos_ff        <= 32'd0;
         built_ff      <= 1'b0;
         clr_cnt_ff    <= 16'd0;
         clr_done_ff   <= 1'b0;
         head_ff       <= 8'd0;
         tail_ff       <= 9'd0;
         sym_i_ff      <= 8'd0;
         pend_v_ff     <= 1'b0;
         rsp_v_ff      <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_cnt_ff <= clr_cnt_ff + 16'd1;
            if (clr_cnt_ff == '1) begin
               clr_done_ff <= 1'b1;
            end
         end
         if (cmd.latch_item) begin
            item_ff <= req_data;
         end
         if (cmd.pat_upd) begin
            nodes_used_ff <= p_nodes;
            if (item_ff.final_byte) begin
               if (!p_drop) begin
                  pat_used_ff <= p_pid;
               end
               ins_node_ff <= 8'd0;
               ins_len_ff  <= 7'd0;
               ins_drop_ff <= 1'b0;
            end else begin
               ins_node_ff <= p_node;
               ins_len_ff  <= p_len;
               ins_drop_ff <= p_drop;
            end
         end
         if (cmd.bld_init) begin
            head_ff  <= 8'd0;
            tail_ff  <= 9'd0;
            sym_i_ff <= 8'd0;
         end
         if (push_en) begin
            tail_ff <= tail_ff + 9'd1;
         end
         if (cmd.root_chk || cmd.bld_wr) begin
            sym_i_ff <= sym_i_ff + 8'd1;
         end
         if (cmd.q_rd) begin
            head_ff <= head_ff + 8'd1;
         end
         if (cmd.bld_u) begin
            u_ff <= queue_q;
         end
         if (cmd.bld_f) begin
            f_ff <= fail_q;
         end
         if (cmd.set_built) begin
            built_ff <= 1'b1;
         end
         if (cmd.txt_step) begin
            scan_ff <= ga_q;
            j_ff    <= ga_q;
         end
         if (cmd.id_chk) begin
            j_ff  <= fail_q;
            id_ff <= npat_q;
         end
         // a new match pushes the previous one out, not yet known to be the last
         if (cmd.hit_go) begin
            if (pend_v_ff) begin
               rsp_ff <= pend_ff;
            end
            pend_ff   <= hit_rsp;
            pend_v_ff <= 1'b1;
         end
         if (cmd.txt_end) begin
            if (pend_v_ff) begin
               rsp_ff <= pend_last;
            end
            pend_v_ff <= 1'b0;
            pos_ff    <= pos_ff + (item_ff.final_byte ? 32'd2 : 32'd1);
            if (item_ff.final_byte) begin
               scan_ff <= 8'd0;
            end
         end
         if (cmd.load_ovf) begin
            rsp_ff <= '{status: STATUS_DROP, match_id: 8'd0, match_total: 32'd0,
                        start_offset: 32'd0, last_of_run: 1'b1};
         end
         if (cmd.load_ovf || ((cmd.hit_go || cmd.txt_end) && pend_v_ff)) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.clear_done = clr_done_ff;
      sts.built      = built_ff;
      sts.out_room   = out_room;
      sts.pat_ovf    = p_ovf;
      sts.sym_last   = sym_i_ff == 8'hFF;
      sts.q_empty    = {1'b0, head_ff} == tail_ff;
      sts.j_zero     = j_ff == 8'd0;
      sts.id_zero    = npat_q == 8'd0;
      sts.pend_valid = pend_v_ff;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   `MPM_ASSERT_SAME(a_drop_zero, rsp_v_ff && rsp_ff.status == STATUS_DROP, rsp_ff.match_id == 8'd0 && rsp_ff.last_of_run, "drop item carries data")
   `MPM_ASSERT_SAME(a_len_cap, 1'b1, ins_len_ff <= 7'(MAX_PATTERN_LEN), "pattern length past limit")
   `MPM_ASSERT_SAME(a_queue_order, 1'b1, {1'b0, head_ff} <= tail_ff, "queue head passed tail")
   `MPM_ASSERT_SAME(a_match_id, rsp_v_ff && rsp_ff.status == STATUS_MATCH, rsp_ff.match_id != 8'd0, "match without id")

endmodule

[src/multi_pattern_matcher_top.sv]
// Top level of the Aho-Corasick multi-pattern matcher.
// After reset the block sweeps its 65536-entry transition memory and per-node stores, one
// entry a cycle, and only then takes its first item. A pattern byte then reads the transition
// memory, updates the trie and, when a pattern ends dropped, waits for the result register. A
// build item scans the root row symbol by symbol, then for every queued trie node reads its
// fail link and reads and writes the transition memory symbol by symbol. A text byte steps the
// automaton and walks the fail chain; every memory read there is registered, so each chain
// node takes a read state and a decision state, and each match a hit state. Results leave
// through one output register; the last result of a text byte carries last_of_run.
module multi_pattern_matcher_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpm_pkg::rsp_type rsp_data
);
   import mpm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mpm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/multi_pattern_matcher_top_tb.sv]
// Self-checking testbench for the multi-pattern matcher: random bursts, stalls, in-order checks.
module multi_pattern_matcher_top_tb;
   import mpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      req_type it;
      bit      hold;   // wait for all results before offering this item
   } pend_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   multi_pattern_matcher_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // matcher state mirror
   logic [7:0]  trie_next [GOTO_DEPTH];
   logic [7:0]  fail_of [TRIE_NODES];
   logic [7:0]  id_at [TRIE_NODES];
   logic [6:0]  len_of [TRIE_NODES];
   logic [31:0] hits [TRIE_NODES];
   int unsigned node_count, pat_count, ins_node, ins_len, scan_at;
   logic [31:0] stream_pos;
   bit          ins_dropped, built;

   pend_type    pending [$];
   rsp_type     match_q [$];
   int          errors = 0;
   int          items_done = 0, results_seen = 0, drops_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #30ms;
      $display("timeout at %0t", $realtime);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void reset_mirror();
      for (int i = 0; i < GOTO_DEPTH; i++) trie_next[i] = '0;
      for (int i = 0; i < TRIE_NODES; i++) begin
         fail_of[i] = '0; id_at[i] = '0; len_of[i] = '0; hits[i] = '0;
      end
      node_count = 0; pat_count = 0; ins_node = 0; ins_len = 0; scan_at = 0;
      stream_pos = '0; ins_dropped = 0; built = 0;
   endfunction

   function automatic void build_links();
      int unsigned fifo [$];
      int unsigned u, f, v;
      for (int s = 0; s < ALPHABET; s++)
         if (trie_next[s] != 0) fifo.push_back(trie_next[s]);
      while (fifo.size() != 0) begin
         u = fifo.pop_front();
         f = fail_of[u];
         for (int s = 0; s < ALPHABET; s++) begin
            v = trie_next[u * ALPHABET + s];
            if (v != 0) begin
               fail_of[v] = trie_next[f * ALPHABET + s];
               fifo.push_back(v);
            end else begin
               trie_next[u * ALPHABET + s] = trie_next[f * ALPHABET + s];
            end
         end
      end
   endfunction

   // expected results of one accepted item
   function automatic void predict_matches(req_type it);
      rsp_type r;
      rsp_type batch [$];
      int unsigned child, j, steps;
      case (it.kind)
         KIND_PATTERN: if (!built) begin
            if (!ins_dropped) begin
               if (ins_len >= MAX_PATTERN_LEN) ins_dropped = 1;
               else begin
                  child = trie_next[ins_node * ALPHABET + it.symbol];
                  if (child == 0) begin
                     if (node_count + 1 >= TRIE_NODES) ins_dropped = 1;
                     else begin
                        node_count++;
                        child = node_count;
                        trie_next[ins_node * ALPHABET + it.symbol] = child[7:0];
                     end
                  end
                  if (!ins_dropped) begin
                     ins_node = child;
                     ins_len++;
                  end
               end
            end
            if (it.final_byte) begin
               if (!ins_dropped && pat_count >= MAX_PATTERNS) ins_dropped = 1;
               if (ins_dropped) begin
                  r = '0;
                  r.status = STATUS_DROP;
                  r.last_of_run = 1'b1;
                  match_q.push_back(r);
               end else begin
                  pat_count++;
                  id_at[ins_node] = pat_count[7:0];
                  len_of[pat_count] = ins_len[6:0];
               end
               ins_node = 0; ins_len = 0; ins_dropped = 0;
            end
         end
         KIND_BUILD: if (!built) begin
            build_links();
            built = 1;
         end
         KIND_TEXT: begin
            scan_at = trie_next[scan_at * ALPHABET + it.symbol];
            j = scan_at;
            steps = 0;
            while (j != 0 && steps < TRIE_NODES && batch.size() < 64) begin
               if (id_at[j] != 0) begin
                  hits[id_at[j]] = hits[id_at[j]] + 1;
                  r = '0;
                  r.status = STATUS_MATCH;
                  r.match_id = id_at[j];
                  r.match_total = hits[id_at[j]];
                  r.start_offset = stream_pos - 32'(len_of[id_at[j]]) + 32'd1;
                  batch.push_back(r);
               end
               j = fail_of[j];
               steps++;
            end
            if (batch.size() != 0) batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[k]) match_q.push_back(batch[k]);
            stream_pos = stream_pos + 32'd1;
            if (it.final_byte) begin
               stream_pos = stream_pos + 32'd1;
               scan_at = 0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic add_item(logic [1:0] kind, logic [7:0] sym, logic fin, bit hold = 0);
      pend_type p;
      p.it.kind = kind;
      p.it.symbol = sym;
      p.it.final_byte = fin;
      p.hold = hold;
      pending.push_back(p);
   endtask

   function automatic logic [7:0] pick_sym(int pct_small);
      if ($urandom_range(0, 99) < pct_small) return 8'h61 + 8'($urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   // sender: bursts with random gaps
   int burst_left = 4, gap_left = 0;
   always @(posedge clock) begin : driver
      logic     take, nv;
      req_type  nd;
      pend_type nx;
      take = req_valid && req_ready;
      nv = req_valid;
      nd = req_data;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (take) begin
            predict_matches(req_data);
            items_done++;
         end
         if (!req_valid || take) begin
            nv = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() != 0 && !(pending[0].hold && match_q.size() != 0)) begin
               nv = 1'b1;
               nx = pending.pop_front();
               nd = nx.it;
               if (--burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
      req_valid <= nv;
      req_data <= nd;
   end

   // receiver: random ready with changing duty, one long hold-off
   int hold_left = 0, duty = 100, duty_cnt = 0;
   bit held_once = 0;
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.status == STATUS_DROP) drops_seen++;
            if (match_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected item %p", $realtime, rsp_data);
            end else begin
               want = match_q.pop_front();
               if (rsp_data.status !== want.status)
                  $display("%0t: status exp %0d got %0d", $realtime, want.status, rsp_data.status);
               if (rsp_data.match_id !== want.match_id)
                  $display("%0t: match_id exp %0d got %0d", $realtime,
                           want.match_id, rsp_data.match_id);
               if (rsp_data.match_total !== want.match_total)
                  $display("%0t: match_total exp %0d got %0d", $realtime,
                           want.match_total, rsp_data.match_total);
               if (rsp_data.start_offset !== want.start_offset)
                  $display("%0t: start_offset exp %0d got %0d", $realtime,
                           want.start_offset, rsp_data.start_offset);
               if (rsp_data.last_of_run !== want.last_of_run)
                  $display("%0t: last_of_run exp %0d got %0d", $realtime,
                           want.last_of_run, rsp_data.last_of_run);
               if (rsp_data !== want) errors++;
            end
         end
         if (++duty_cnt >= 64) begin
            duty_cnt = 0;
            case ($urandom_range(0, 2))
               0: duty = 100;
               1: duty = 60;
               default: duty = 20;
            endcase
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held_once && results_seen >= 20) begin
            held_once = 1;
            hold_left = 500;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < duty);
         end
      end
   end

   initial begin
      int len;
      reset_mirror();
      // directed: extremes, duplicate, unused kind, text on the partial trie
      add_item(KIND_PATTERN, 8'h61, 1'b1);
      add_item(KIND_PATTERN, 8'h61, 1'b0);
      add_item(KIND_PATTERN, 8'h62, 1'b1);
      add_item(KIND_PATTERN, 8'h00, 1'b1);
      add_item(KIND_PATTERN, 8'hFF, 1'b0);
      add_item(KIND_PATTERN, 8'hFF, 1'b1);
      add_item(KIND_PATTERN, 8'h61, 1'b1);       // duplicate replaces the old id
      add_item(2'd3, 8'hFF, 1'b1);               // unused kind
      add_item(KIND_TEXT, 8'h61, 1'b0);
      add_item(KIND_TEXT, 8'h62, 1'b1);
      add_item(KIND_TEXT, 8'hFF, 1'b0);
      add_item(KIND_TEXT, 8'hFF, 1'b1);
      add_item(KIND_TEXT, 8'h00, 1'b0);
      add_item(KIND_TEXT, 8'h5A, 1'b1);
      // random patterns, one of them too long with fresh bytes; helps fill the trie
      for (int p = 0; p < 70; p++) begin
         len = (p == 20) ? 66 : $urandom_range(1, 3);
         for (int b = 0; b < len; b++)
            add_item(KIND_PATTERN, pick_sym((p == 20) ? 0 : ((p % 2) ? 90 : 10)),
                     b == len - 1);
         if ($urandom_range(0, 9) == 0) add_item(2'd3, 8'($urandom), 1'($urandom));
      end
      // single-byte patterns run the ids out and fill the trie
      for (int p = 0; p < 190; p++) add_item(KIND_PATTERN, pick_sym(40), 1'b1);
      add_item(KIND_PATTERN, 8'h63, 1'b0);       // left open at the build
      add_item(KIND_BUILD, 8'($urandom), 1'b0, 1);
      add_item(KIND_BUILD, 8'($urandom), 1'b1);  // second build ignored
      add_item(KIND_PATTERN, 8'h61, 1'b1);       // ignored after build
      add_item(KIND_TEXT, 8'h00, 1'b0, 1);
      add_item(KIND_TEXT, 8'hFF, 1'b1);
      for (int t = 0; t < 50; t++) begin
         case ($urandom_range(0, 19))
            0: add_item(2'd3, 8'($urandom), 1'($urandom));
            1: add_item(KIND_PATTERN, 8'($urandom), 1'($urandom));
            default: add_item(KIND_TEXT, pick_sym(85), $urandom_range(0, 7) == 0);
         endcase
         if (t == 25) add_item(KIND_TEXT, pick_sym(85), 1'b0, 1);
      end

      wait (!reset);
      wait (pending.size() == 0 && !req_valid);
      wait (match_q.size() == 0);
      repeat (300) @(posedge clock);
      if (match_q.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $realtime, match_q.size());
      end
      $display("covered %0d items, %0d results (%0d capacity drops), %0d patterns, %0d nodes",
               items_done, results_seen, drops_seen, pat_count, node_count);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[multi_pattern_matcher_top.f]
+incdir+src
src/mpm_pkg.sv
src/mpm_ctrl.sv
src/mpm_dp.sv
src/multi_pattern_matcher_top.sv
tb/sv/multi_pattern_matcher_top_tb.sv
